// File: rtl/modular_exponentiation_core_macros.svh
// ============================================================================
// Modular exponentiation core: assertion macros
// Shared helpers for writing the concurrent checks of the core's modules.
// ============================================================================
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MEXP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MEXP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
// ============================================================================
// Modular exponentiation package
// Types, codes and constants shared by the controller and the datapath.
// ============================================================================
`default_nettype none

package mexp_pkg;

   // Default operand width and the fixed width of the request and response data.
   localparam int unsigned OPERAND_BITS_DEF = 32;
   localparam int unsigned DATA_BITS        = 32;

   // Register file layout.
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 1'b1;

   // Operation started on the modular multiplier.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_REDUCE,
      OP_SQUARE,
      OP_MULT
   } mexp_op_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_RED_WAIT,
      S_SCAN,
      S_SQ_WAIT,
      S_MUL_ISSUE,
      S_MUL_WAIT,
      S_DONE
   } mexp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      mexp_op_type mul_op;
      logic        acc_set_one;
      logic        acc_load;
      logic        b_load;
      logic        out_load;
   } mexp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;
   } mexp_status_type;

endpackage

`default_nettype wire

// File: rtl/mexp_modmul.sv
// ============================================================================
// Bit-serial modular multiplier
// Computes x * y mod n by interleaved shift-and-add, one bit of x per cycle.
// ============================================================================
`default_nettype none
`include "modular_exponentiation_core_macros.svh"

module mexp_modmul #(
   parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [OPERAND_BITS-1:0] x,
   input  wire logic [OPERAND_BITS-1:0] y,
   input  wire logic [OPERAND_BITS-1:0] n,
   output logic                         done,
   output logic [OPERAND_BITS-1:0]      r
);

   localparam int unsigned W  = OPERAND_BITS;
   localparam int unsigned TW = OPERAND_BITS + 2;
   localparam int unsigned CW = $clog2(OPERAND_BITS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  r_ff, r_in;

   logic [TW-1:0] t, n1, n2;

   // The running remainder stays below n, and y never exceeds n, so the sum
   // 2r + y is below 3n and at most two subtractions of n bring it back.
   always_comb begin
      n1 = TW'(n);
      n2 = {1'b0, n, 1'b0};
      t  = {1'b0, r_ff, 1'b0} + (x_ff[W-1] ? TW'(y_ff) : '0);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W - 1);
         x_in    = x;
         y_in    = y;
         r_in    = '0;
      end else if (busy_ff) begin
         x_in = x_ff << 1;
         if (t >= n2) begin
            r_in = W'(t - n2);
         end else if (t >= n1) begin
            r_in = W'(t - n1);
         end else begin
            r_in = W'(t);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign r    = r_ff;

   `MEXP_ASSERT_IMP(a_result_reduced, clock, reset, done_ff, r_ff < n, "product not reduced")
   `MEXP_ASSERT_IMP(a_no_start_busy, clock, reset, start, !busy_ff, "start while busy")

endmodule

`default_nettype wire

// File: rtl/mexp_dp.sv
// ============================================================================
// Modular exponentiation datapath
// Holds the modulus, reduced base, accumulator and result register.
// ============================================================================
`default_nettype none

module mexp_dp #(
   parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mexp_pkg::DATA_BITS-1:0]        csr_wdata,
   input  wire logic [mexp_pkg::DATA_BITS-1:0]        req_tdata,
   input  wire mexp_pkg::mexp_cmd_type                cmd,
   output mexp_pkg::mexp_status_type                  status,
   output logic [mexp_pkg::DATA_BITS-1:0]             rsp_tdata
);

   localparam int unsigned W = OPERAND_BITS;

   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] out_ff, out_in;

   logic [W-1:0] wdata;
   logic         mul_start;
   logic [W-1:0] mul_x, mul_y, mul_r;
   logic         mul_done;

   assign wdata = csr_wdata[W-1:0];

   // A zero modulus write is dropped, so the modulus is never zero.
   always_comb begin
      mod_in = mod_ff;
      if (csr_we && csr_index == mexp_pkg::CSR_MODULUS && wdata != '0) begin
         mod_in = wdata;
      end
   end

   // Operand selection for the shared multiplier. The base is reduced as
   // base * 1 straight from the request data in the cycle it is accepted.
   always_comb begin
      mul_start = 1'b1;
      mul_x     = acc_ff;
      mul_y     = acc_ff;
      case (cmd.mul_op)
         mexp_pkg::OP_REDUCE: begin
            mul_x = req_tdata[W-1:0];
            mul_y = W'(1);
         end
         mexp_pkg::OP_SQUARE: begin
            mul_y = acc_ff;
         end
         mexp_pkg::OP_MULT: begin
            mul_y = b_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      b_in   = b_ff;
      out_in = out_ff;
      if (cmd.acc_set_one) begin
         acc_in = W'(1);
      end else if (cmd.acc_load) begin
         acc_in = mul_r;
      end
      if (cmd.b_load) begin
         b_in = mul_r;
      end
      if (cmd.out_load) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= W'(1);
      end else begin
         mod_ff <= mod_in;
      end
      acc_ff <= acc_in;
      b_ff   <= b_in;
      out_ff <= out_in;
   end

   mexp_modmul #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_modmul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .x    (mul_x),
      .y    (mul_y),
      .n    (mod_ff),
      .done (mul_done),
      .r    (mul_r)
   );

   assign status.mul_done = mul_done;
   assign rsp_tdata       = mexp_pkg::DATA_BITS'(out_ff);

endmodule

`default_nettype wire

// File: rtl/mexp_ctrl.sv
// ============================================================================
// Modular exponentiation controller
// Sequences base reduction and the square-and-multiply steps per request.
// ============================================================================
`default_nettype none
`include "modular_exponentiation_core_macros.svh"

module mexp_ctrl #(
   parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mexp_pkg::DATA_BITS-1:0]        csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire mexp_pkg::mexp_status_type             status,
   output mexp_pkg::mexp_cmd_type                     cmd
);

   localparam int unsigned W  = OPERAND_BITS;
   localparam int unsigned CW = $clog2(OPERAND_BITS);

   mexp_pkg::mexp_state_type state_ff, state_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [CW-1:0] bit_ff, bit_in;
   logic          started_ff, started_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_accept;
   logic          exp_bit;
   logic          mul_waiting;

   assign req_tready = (state_ff == mexp_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exp_bit    = exp_ff[bit_ff];

   // The states in which a multiplier result is expected.
   assign mul_waiting = state_ff inside {mexp_pkg::S_RED_WAIT, mexp_pkg::S_SQ_WAIT,
                                         mexp_pkg::S_MUL_WAIT};

   always_comb begin
      exp_in = exp_ff;
      if (csr_we && csr_index == mexp_pkg::CSR_EXPONENT) begin
         exp_in = csr_wdata[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::S_IDLE;
         exp_ff       <= '0;
         bit_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         bit_ff       <= bit_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      bit_in           = bit_ff;
      started_in       = started_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      cmd.mul_op       = mexp_pkg::OP_NONE;
      cmd.acc_set_one  = 1'b0;
      cmd.acc_load     = 1'b0;
      cmd.b_load       = 1'b0;
      cmd.out_load     = 1'b0;

      case (state_ff)
         mexp_pkg::S_IDLE: begin
            if (req_accept) begin
               bit_in     = CW'(W - 1);
               started_in = 1'b0;
               if (exp_ff == '0) begin
                  cmd.acc_set_one = 1'b1;
                  state_in        = mexp_pkg::S_DONE;
               end else begin
                  cmd.mul_op = mexp_pkg::OP_REDUCE;
                  state_in   = mexp_pkg::S_RED_WAIT;
               end
            end
         end
         mexp_pkg::S_RED_WAIT: begin
            if (status.mul_done) begin
               cmd.b_load      = 1'b1;
               cmd.acc_set_one = 1'b1;
               state_in        = mexp_pkg::S_SCAN;
            end
         end
         mexp_pkg::S_SCAN: begin
            // Leading zero bits of the exponent are skipped one a cycle.
            if (started_ff || exp_bit) begin
               started_in = 1'b1;
               cmd.mul_op = mexp_pkg::OP_SQUARE;
               state_in   = mexp_pkg::S_SQ_WAIT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         mexp_pkg::S_SQ_WAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               if (exp_bit) begin
                  state_in = mexp_pkg::S_MUL_ISSUE;
               end else if (bit_ff == '0) begin
                  state_in = mexp_pkg::S_DONE;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = mexp_pkg::S_SCAN;
               end
            end
         end
         mexp_pkg::S_MUL_ISSUE: begin
            cmd.mul_op = mexp_pkg::OP_MULT;
            state_in   = mexp_pkg::S_MUL_WAIT;
         end
         mexp_pkg::S_MUL_WAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               if (bit_ff == '0) begin
                  state_in = mexp_pkg::S_DONE;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = mexp_pkg::S_SCAN;
               end
            end
         end
         mexp_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mexp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MEXP_ASSERT_IMP(a_done_when_waiting, clock, reset, status.mul_done, mul_waiting, "unexpected done")
   `MEXP_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, !req_tready, "request not started")

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_core.sv
// ============================================================================
// Modular exponentiation core
// Raises each request's base to a configured exponent modulo a configured modulus.
// ============================================================================
// Each request carries one base; the core answers with base^exponent mod
// modulus, computed by left-to-right square-and-multiply from the most
// significant set bit of the exponent, and answers 1 whenever the exponent is
// zero. Only the low OPERAND_BITS bits of the base and of both registers are
// used, and a write of zero to the modulus is ignored, so the modulus is never
// zero. Every modular product goes through one shared bit-serial multiplier
// that handles one bit of its first operand per cycle, and that unit sets the
// throughput: it reduces the base, then squares once for each exponent bit
// from the highest set bit down and multiplies once for each set bit, while
// leading zero bits are skipped without the multiplier; a final step hands
// the result over, and a zero exponent skips the multiplier altogether.
// Requests are handled one at a time, but the result sits in its own
// register, so the next request is accepted as soon as the previous
// computation has finished, even while the response still waits to be
// taken. Registers may only be written while no request is in flight.
// ============================================================================
`default_nettype none

module modular_exponentiation_core #(
   parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Register write port: index 0 exponent, index 1 modulus.
   input  wire logic                                  csr_we,
   input  wire logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mexp_pkg::DATA_BITS-1:0]        csr_wdata,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [mexp_pkg::DATA_BITS-1:0]        req_tdata,  // [31:0] base
   // Response channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [mexp_pkg::DATA_BITS-1:0]             rsp_tdata   // [31:0] power
);

   // The controller and the datapath talk only through these two bundles.
   mexp_pkg::mexp_cmd_type    cmd;
   mexp_pkg::mexp_status_type status;

   // The controller owns the exponent register, the sequencing and the
   // response valid flag.
   mexp_ctrl #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the modulus, the reduced base, the accumulator, the
   // shared multiplier and the response data register.
   mexp_dp #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tdata(req_tdata),
      .cmd      (cmd),
      .status   (status),
      .rsp_tdata(rsp_tdata)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
// ============================================================================
// Modular exponentiation core testbench
// Sends bases under many exponent and modulus settings and checks every
// response against a square-and-multiply predictor kept inside the bench.
// ============================================================================
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   // A full-width exponent squares and multiplies per bit, and a response may
   // wait out a long random stall, so this is far beyond any correct run.
   localparam int unsigned STALL_LIMIT = 50000;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned BASES_PER_PHASE = 23;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  csr_we = 1'b0;
   logic [mexp_pkg::CSR_INDEX_BITS-1:0]   csr_index = mexp_pkg::CSR_EXPONENT;
   logic [mexp_pkg::DATA_BITS-1:0]        csr_wdata = '0;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [mexp_pkg::DATA_BITS-1:0]        req_tdata = '0;    // [31:0] base
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [mexp_pkg::DATA_BITS-1:0]        rsp_tdata;         // [31:0] power

   // Bench copy of the two registers, as the core should hold them.
   logic [31:0] exponent_setting = 32'd0;
   logic [31:0] modulus_setting  = 32'd1;

   logic [31:0] pending_bases[$];
   logic [31:0] expected_powers[$];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned error_count        = 0;
   int unsigned quiet_cycles       = 0;

   modular_exponentiation_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Left-to-right square-and-multiply from the highest set exponent bit.
   // Both operands are below 2^32, so every product is exact in 64 bits.
   // A zero exponent gives 1 without any reduction, even for modulus one.
   function automatic logic [31:0] modular_power(input logic [31:0] base,
                                                 input logic [31:0] exponent,
                                                 input logic [31:0] modulus);
      logic [63:0] acc;
      int          top;
      if (exponent == 32'd0) begin
         return 32'd1;
      end
      top = 31;
      while (top > 0 && !exponent[top]) begin
         top--;
      end
      acc = 64'd1;
      for (int i = top; i >= 0; i--) begin
         acc = (acc * acc) % {32'd0, modulus};
         if (exponent[i]) begin
            acc = ({32'd0, base} * acc) % {32'd0, modulus};
         end
      end
      return acc[31:0];
   endfunction

   // Request driver. A new base is offered only once the previous one has
   // been taken, so valid never drops while a request is still on offer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_powers.push_back(
               modular_power(req_tdata, exponent_setting, modulus_setting));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bases.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               req_tdata  <= pending_bases.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: each response is matched with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_powers.size() == 0) begin
               $display("%0t: unexpected response, actual power %h", $time, rsp_tdata);
               error_count++;
            end else if (rsp_tdata !== expected_powers[0]) begin
               $display("%0t: power mismatch, expected %h, actual %h",
                        $time, expected_powers[0], rsp_tdata);
               error_count++;
               void'(expected_powers.pop_front());
            end else begin
               void'(expected_powers.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: too long without any request or response moving ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write; the bench copy follows the same rule as the core,
   // which ignores a zero written to the modulus.
   task automatic write_register(input logic [mexp_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == mexp_pkg::CSR_EXPONENT) begin
         exponent_setting = value;
      end else if (index == mexp_pkg::CSR_MODULUS && value != 32'd0) begin
         modulus_setting = value;
      end
   endtask

   task automatic configure(input logic [31:0] exponent, input logic [31:0] modulus);
      write_register(mexp_pkg::CSR_EXPONENT, exponent);
      write_register(mexp_pkg::CSR_MODULUS, modulus);
   endtask

   // Holds the sender back until every request has been answered. Sampled on
   // the falling edge, when the driver and monitor have settled for the cycle.
   task automatic drain();
      @(negedge clock);
      while (pending_bases.size() > 0 || req_tvalid || expected_powers.size() > 0) begin
         @(negedge clock);
      end
   endtask

   // Four idling regimes, taken in turn by the random phases.
   task automatic set_idling(input int unsigned mode);
      case (mode % 4)
         0: begin
            sender_idle_pct = 0;  receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct = 64; receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct = 0;  receiver_stall_pct = 64;
         end
         default: begin
            sender_idle_pct = 27; receiver_stall_pct = 27;
         end
      endcase
   endtask

   initial begin
      logic [31:0] exponent;
      logic [31:0] modulus;
      int unsigned bits;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Straight after reset: zero exponent with modulus one still gives 1.
      pending_bases.push_back(32'h0000_0000);
      pending_bases.push_back(32'hFFFF_FFFF);
      drain();

      // A zero modulus write is dropped, so the modulus stays one and any
      // nonzero exponent gives 0.
      configure(32'd5, 32'd0);
      pending_bases.push_back(32'd7);
      pending_bases.push_back(32'd0);
      drain();

      // Largest exponent and modulus; bases at and below the modulus.
      set_idling(3);
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      pending_bases.push_back(32'h0000_0000);
      pending_bases.push_back(32'h0000_0001);
      pending_bases.push_back(32'hFFFF_FFFF);
      pending_bases.push_back(32'hFFFF_FFFE);
      pending_bases.push_back(32'h0000_0002);
      drain();

      // Exponent one, with one base above the modulus: the result is the base
      // reduced modulo the modulus.
      configure(32'd1, 32'hFFFF_FFFB);
      pending_bases.push_back(32'hFFFF_FFFF);
      pending_bases.push_back(32'd5);
      pending_bases.push_back(32'h8000_0000);
      drain();

      // Only the top exponent bit set: one multiply, then 31 squarings with no multiply.
      // The zero modulus write must leave the previous modulus in place.
      configure(32'h8000_0000, 32'd0);
      pending_bases.push_back(32'd3);
      pending_bases.push_back(32'hFFFF_FFFF);
      drain();

      configure(32'd2, 32'd2);
      pending_bases.push_back(32'hFFFF_FFFF);
      pending_bases.push_back(32'h1234_5678);
      drain();

      configure(32'd3, 32'h8000_0000);
      pending_bases.push_back(32'hAAAA_AAAA);
      pending_bases.push_back(32'h5555_5555);
      drain();

      // Zero exponent with an ordinary modulus.
      configure(32'd0, 32'h0001_0001);
      pending_bases.push_back(32'hDEAD_BEEF);
      drain();

      // Random phases. Exponents are mostly short to keep the run brisk; a
      // few use the full width. Each phase ends with the sender held back
      // until every request has been answered.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(phase);
         case ($urandom_range(0, 9))
            0:       bits = 0;
            1:       bits = 32;
            2, 3:    bits = $urandom_range(11, 20);
            default: bits = $urandom_range(1, 10);
         endcase
         if (bits == 0) begin
            exponent = 32'd0;
         end else begin
            exponent = $urandom & (32'hFFFF_FFFF >> (32 - bits));
            exponent[bits-1] = 1'b1;
         end
         case ($urandom_range(0, 5))
            0:       modulus = $urandom_range(1, 255);
            1:       modulus = 32'hFFFF_FFFF;
            2:       modulus = 32'd1 << $urandom_range(0, 31);
            3:       modulus = 32'd1;
            4:       modulus = $urandom_range(2, 65535);
            default: modulus = $urandom | 32'd1;
         endcase
         configure(exponent, modulus);
         if ($urandom_range(0, 3) == 0) begin
            write_register(mexp_pkg::CSR_MODULUS, 32'd0);
         end
         for (int n = 0; n < BASES_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0:       pending_bases.push_back(32'd0);
               1:       pending_bases.push_back(32'd1);
               2:       pending_bases.push_back(modulus_setting - 32'd1);
               3:       pending_bases.push_back(modulus_setting);
               4:       pending_bases.push_back(32'hFFFF_FFFF);
               5:       pending_bases.push_back($urandom_range(0, 255));
               default: pending_bases.push_back($urandom);
            endcase
         end
         drain();
      end

      // Give a stray late response time to show itself.
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
